/* hdl/blpk_pkg.sv */
// Shared types and constants for the byte lane data packer.
package blpk_pkg;

  localparam int ADDR_BITS = 16;
  localparam int OUT_ADDR_W = 16;
  localparam int DATA_W = 32;
  localparam int VB_W = 3;

  localparam logic [15:0] START_RESET = 16'd100;
  localparam logic [VB_W-1:0] BYTES_PER_WORD = 3'd4;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_HALF = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;
  localparam logic [1:0] MODE_FLUSH = 2'd3;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    addr_t             address;
    logic [DATA_W-1:0] partial;
  } pack_state_t;

  typedef struct packed {
    logic                  emit;
    logic [OUT_ADDR_W-1:0] word_address;
    logic [DATA_W-1:0]     word_data;
    logic [VB_W-1:0]       valid_bytes;
  } pack_result_t;

endpackage

/* hdl/blpk_merge.sv */
// Byte lane placement and merge of one item into the partial word.
module blpk_merge (
  input  logic [1:0]             mode,
  input  logic [31:0]            value,
  input  blpk_pkg::pack_state_t  cur,
  output blpk_pkg::pack_state_t  nxt,
  output blpk_pkg::pack_result_t res
);
  import blpk_pkg::*;

  logic [1:0]          lane;
  logic [4:0]          shamt;
  logic [2:0]          nbytes;
  logic [DATA_W-1:0]   val_m;
  logic [2*DATA_W-1:0] merged;
  logic [2:0]          fill;
  addr_t               aligned;

  always_comb begin
    lane = cur.address[1:0];
    shamt = {lane, 3'b000};
    aligned = {cur.address[ADDR_BITS-1:2], 2'b00};

    unique case (mode)
      MODE_BYTE: begin
        nbytes = 3'd1;
        val_m = {24'd0, value[7:0]};
      end
      MODE_HALF: begin
        nbytes = 3'd2;
        val_m = {16'd0, value[15:0]};
      end
      MODE_WORD: begin
        nbytes = 3'd4;
        val_m = value;
      end
      MODE_FLUSH: begin
        nbytes = 3'd0;
        val_m = '0;
      end
    endcase

    // Bytes shifted past lane 3 land in the upper half and seed the next word.
    merged = {{DATA_W{1'b0}}, cur.partial} | ({{DATA_W{1'b0}}, val_m} << shamt);
    fill = {1'b0, lane} + nbytes;

    nxt = cur;
    res.emit = 1'b0;
    res.word_address = OUT_ADDR_W'(aligned);
    res.word_data = merged[DATA_W-1:0];
    res.valid_bytes = BYTES_PER_WORD;

    if (mode == MODE_FLUSH) begin
      // A flush on an aligned address has nothing to send.
      if (lane != 2'd0) begin
        res.emit = 1'b1;
        res.word_data = cur.partial & ~({DATA_W{1'b1}} << shamt);
        res.valid_bytes = {1'b0, lane};
        nxt.partial = '0;
      end
    end else begin
      nxt.address = cur.address + addr_t'(nbytes);
      if (fill >= 3'd4) begin
        res.emit = 1'b1;
        nxt.partial = merged[2*DATA_W-1:DATA_W];
      end else begin
        nxt.partial = merged[DATA_W-1:0];
      end
    end
  end

endmodule

/* hdl/byte_lane_data_packer_core.sv */
// Output: a result appears in the output register the cycle after its input transfer.
// Throughput: one item per cycle while the output is not stalled; the single output register takes a new result
// in the same cycle that the old one is transferred out.
// Reset: synchronous; the running address returns to 100, the partial word to zero,
// and the output register is emptied. A start_address write reloads both.
// Top level: the byte lane data packer core.
module byte_lane_data_packer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] word_address,
  output logic [31:0] word_data,
  output logic [2:0]  valid_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] start_address
);
  import blpk_pkg::*;

  pack_state_t  state;
  pack_state_t  state_next;
  pack_result_t res;
  logic         in_fire;
  logic         cfg_fire;

  blpk_merge u_merge (
    .mode  (mode),
    .value (value),
    .cur   (state),
    .nxt   (state_next),
    .res   (res)
  );

  assign in_ready = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.address <= addr_t'(START_RESET);
      state.partial <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_fire) begin
        state.address <= addr_t'(start_address);
        state.partial <= '0;
      end else if (in_fire) begin
        state <= state_next;
      end

      if (in_fire) begin
        out_valid <= res.emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.emit) begin
      word_address <= res.word_address;
      word_data <= res.word_data;
      valid_bytes <= res.valid_bytes;
    end
  end

endmodule

/* hdl/blpk_checker.sv */
// Port-level assertions for the packer core and the bind that attaches them.
module blpk_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] word_address,
  input logic [31:0] word_data,
  input logic [2:0]  valid_bytes
);
  import blpk_pkg::*;

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_data) &&
      $stable(word_address) && $stable(valid_bytes))
    else $error("stalled result changed");

  // With one output register, a stalled result blocks new input transfers.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // A word item always completes a word, so a full result follows.
  a_word_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_WORD |=>
      out_valid && valid_bytes == BYTES_PER_WORD && word_address[1:0] == 2'b00)
    else $error("word transfer gave no full result");

endmodule

bind byte_lane_data_packer_core blpk_checker u_blpk_checker (.*);

/* dv/byte_lane_data_packer_core_test.sv */
// Self-checking testbench for the byte lane data packer core.
module byte_lane_data_packer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blpk_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
  } feed_item_t;

  typedef struct {
    logic [15:0] addr;
    logic [31:0] data;
    logic [2:0]  nbytes;
  } packed_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_BYTE;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] word_address;
  logic [31:0] word_data;
  logic [2:0]  valid_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] start_address = '0;

  feed_item_t   pending_items_q[$];
  packed_word_t packed_words_q[$];
  feed_item_t   next_item;
  packed_word_t got_word;

  // Packer state as the block should hold it.
  addr_t       pk_addr;
  logic [31:0] pk_word;

  int  mismatch_count = 0;
  int  feed_wait = 0;
  int  drain_wait = 0;
  bit  feed_calm = 1'b0;
  bit  drain_calm = 1'b0;

  byte_lane_data_packer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word_address (word_address),
    .word_data    (word_data),
    .valid_bytes  (valid_bytes),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .start_address(start_address)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int draw_wait(bit calm);
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Merges one accepted item into the packer state and queues any word it completes or flushes.
  task automatic pack_value(logic [1:0] m, logic [31:0] v);
    logic [1:0]   lane;
    logic [2:0]   nb;
    logic [31:0]  data;
    logic [63:0]  merged;
    packed_word_t w;
    lane = pk_addr[1:0];
    w.addr = {pk_addr[15:2], 2'b00};
    if (m == MODE_FLUSH) begin
      if (lane != 2'd0) begin
        w.data = pk_word & ((32'd1 << (8 * lane)) - 32'd1);
        w.nbytes = {1'b0, lane};
        packed_words_q.push_back(w);
        pk_word = '0;
      end
    end else begin
      case (m)
        MODE_BYTE: begin
          nb = 3'd1;
          data = v & 32'h0000_00FF;
        end
        MODE_HALF: begin
          nb = 3'd2;
          data = v & 32'h0000_FFFF;
        end
        default: begin
          nb = 3'd4;
          data = v;
        end
      endcase
      merged = {32'd0, pk_word} | ({32'd0, data} << (8 * lane));
      pk_addr = pk_addr + addr_t'(nb);
      if ({1'b0, lane} + nb >= BYTES_PER_WORD) begin
        w.data = merged[31:0];
        w.nbytes = BYTES_PER_WORD;
        packed_words_q.push_back(w);
        pk_word = merged[63:32];
      end else begin
        pk_word = merged[31:0];
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      feed_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        pack_value(mode, value);
      end
      if (!in_valid || in_ready) begin
        if (feed_wait > 0) begin
          feed_wait--;
          in_valid <= 1'b0;
        end else if (pending_items_q.size() != 0) begin
          next_item = pending_items_q.pop_front();
          mode <= next_item.mode;
          value <= next_item.value;
          in_valid <= 1'b1;
          if ($urandom_range(0, 29) == 0) begin
            feed_calm = !feed_calm;
          end
          feed_wait = draw_wait(feed_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      drain_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (packed_words_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected word: addr %h data %h bytes %0d",
                     word_address, word_data, valid_bytes);
          end
        end else begin
          got_word = packed_words_q.pop_front();
          if (word_address !== got_word.addr || word_data !== got_word.data ||
              valid_bytes !== got_word.nbytes) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("word mismatch: expected addr %h data %h bytes %0d, got %h %h %0d",
                       got_word.addr, got_word.data, got_word.nbytes,
                       word_address, word_data, valid_bytes);
            end
          end
        end
        if ($urandom_range(0, 29) == 0) begin
          drain_calm = !drain_calm;
        end
        drain_wait = draw_wait(drain_calm);
      end
      if (drain_wait > 0) begin
        drain_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_item(logic [1:0] m, logic [31:0] v);
    feed_item_t it;
    it.mode = m;
    it.value = v;
    pending_items_q.push_back(it);
  endtask

  // Waits for all items to go in and the words they owe to come out, then lets
  // the output register settle, since a flush on an aligned address owes nothing.
  task automatic settle();
    do @(negedge clk); while (pending_items_q.size() != 0 || in_valid);
    for (int i = 0; i < 400 && packed_words_q.size() != 0; i++) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start(logic [15:0] a);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    start_address <= a;
    do @(posedge clk); while (!cfg_ready);
    pk_addr = a;
    pk_word = '0;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_random_items(int count);
    int n;
    int len;
    int k;
    n = 0;
    while (n < count) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        // A short string, terminator included.
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
          add_item(MODE_BYTE, ($urandom() & 32'hFFFF_FF00) | $urandom_range(32, 126));
        end
        add_item(MODE_BYTE, $urandom() & 32'hFFFF_FF00);
        n += len + 1;
      end else if (k < 40) begin
        add_item(MODE_BYTE, pick_value());
        n++;
      end else if (k < 62) begin
        add_item(MODE_HALF, pick_value());
        n++;
      end else if (k < 86) begin
        add_item(MODE_WORD, pick_value());
        n++;
      end else begin
        add_item(MODE_FLUSH, pick_value());
        n++;
      end
    end
  endtask

  initial begin
    pk_addr = addr_t'(START_RESET);
    pk_word = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Start address from reset: byte, halfword and word lanes, high bytes ignored,
    // flushes on aligned and unaligned addresses, a spill past lane 3.
    add_item(MODE_BYTE, 32'h0000_00FF);
    add_item(MODE_BYTE, 32'hABCD_EF12);
    add_item(MODE_HALF, 32'hFFFF_5A3C);
    add_item(MODE_FLUSH, 32'h0000_0000);
    add_item(MODE_BYTE, 32'h0000_0000);
    add_item(MODE_FLUSH, 32'hFFFF_FFFF);
    add_item(MODE_HALF, 32'h5555_1234);
    add_item(MODE_WORD, 32'hFFFF_FFFF);
    add_item(MODE_FLUSH, 32'h0000_0000);
    add_item(MODE_WORD, 32'h0000_0000);
    add_item(MODE_HALF, 32'hFFFF_FFFF);
    add_item(MODE_WORD, 32'h8000_0001);
    add_item(MODE_BYTE, 32'h0000_004F);
    add_item(MODE_BYTE, 32'h0000_004B);
    add_item(MODE_BYTE, 32'h0000_0000);
    add_item(MODE_FLUSH, 32'h0000_0000);

    // The address wraps past the top of the space.
    write_start(16'hFFFE);
    add_item(MODE_WORD, 32'hDEAD_BEEF);
    add_item(MODE_HALF, 32'h7777_C0DE);
    add_item(MODE_FLUSH, 32'h0000_0000);
    write_start(16'hFFFF);
    add_item(MODE_BYTE, 32'h0000_005A);
    add_item(MODE_HALF, 32'h0000_A55A);
    add_item(MODE_FLUSH, 32'h0000_0000);

    write_start(16'h0000);
    add_random_items(175);
    write_start(16'hFFFF);
    add_random_items(175);
    write_start(START_RESET);
    add_random_items(175);
    write_start(16'hFFFC);
    add_random_items(175);
    write_start(16'($urandom_range(0, 65535)));
    add_random_items(175);
    write_start(16'($urandom_range(0, 65535)));
    add_random_items(175);

    settle();
    if (packed_words_q.size() != 0) begin
      $display("%0d expected words never came out", packed_words_q.size());
      mismatch_count += packed_words_q.size();
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
hdl/blpk_pkg.sv
hdl/blpk_merge.sv
hdl/byte_lane_data_packer_core.sv
hdl/blpk_checker.sv
dv/byte_lane_data_packer_core_test.sv
